/* sv/uerc_pkg.sv */
`timescale 1ns / 1ps
// Shared codes and types of the radio connection state machine.
package uerc_pkg;

	localparam int unsigned OP_W     = 4;
	localparam int unsigned STATE_W  = 3;
	localparam int unsigned ACTION_W = 4;
	localparam int unsigned ID_W     = 50;

	// Event codes
	localparam logic [OP_W-1:0] OP_CONNECT      = 4'd0;
	localparam logic [OP_W-1:0] OP_DISCONNECT   = 4'd1;
	localparam logic [OP_W-1:0] OP_CAMP         = 4'd2;
	localparam logic [OP_W-1:0] OP_MIB          = 4'd3;
	localparam logic [OP_W-1:0] OP_SYSINFO      = 4'd4;
	localparam logic [OP_W-1:0] OP_SET_RNTI     = 4'd5;
	localparam logic [OP_W-1:0] OP_RA_OK        = 4'd6;
	localparam logic [OP_W-1:0] OP_RA_FAIL      = 4'd7;
	localparam logic [OP_W-1:0] OP_SETUP        = 4'd8;
	localparam logic [OP_W-1:0] OP_RECONFIG     = 4'd9;
	localparam logic [OP_W-1:0] OP_REESTAB      = 4'd10;
	localparam logic [OP_W-1:0] OP_REESTAB_REJ  = 4'd11;
	localparam logic [OP_W-1:0] OP_RELEASE      = 4'd12;
	localparam logic [OP_W-1:0] OP_REJECT       = 4'd13;
	localparam logic [OP_W-1:0] OP_LAST         = OP_REJECT;

	// Connection states
	localparam logic [STATE_W-1:0] ST_SELECT     = 3'd0;
	localparam logic [STATE_W-1:0] ST_WAITSI     = 3'd1;
	localparam logic [STATE_W-1:0] ST_CAMPED     = 3'd2;
	localparam logic [STATE_W-1:0] ST_RA         = 3'd3;
	localparam logic [STATE_W-1:0] ST_CONNECTING = 3'd4;
	localparam logic [STATE_W-1:0] ST_CONNECTED  = 3'd5;
	localparam logic [STATE_W-1:0] ST_REESTAB    = 3'd6;
	localparam logic [STATE_W-1:0] ST_HANDOVER   = 3'd7;

	// Action codes
	localparam logic [ACTION_W-1:0] ACT_NONE         = 4'd0;
	localparam logic [ACTION_W-1:0] ACT_CONN_REQ     = 4'd1;
	localparam logic [ACTION_W-1:0] ACT_SETUP_DONE   = 4'd2;
	localparam logic [ACTION_W-1:0] ACT_RECONF_DONE  = 4'd3;
	localparam logic [ACTION_W-1:0] ACT_START_HO     = 4'd4;
	localparam logic [ACTION_W-1:0] ACT_LEAVE_CONN   = 4'd5;
	localparam logic [ACTION_W-1:0] ACT_ABORT        = 4'd6;
	localparam logic [ACTION_W-1:0] ACT_MAC_RESET    = 4'd7;
	localparam logic [ACTION_W-1:0] ACT_SYNC_CELL    = 4'd8;
	localparam logic [ACTION_W-1:0] ACT_SET_DL_BW    = 4'd9;
	localparam logic [ACTION_W-1:0] ACT_CONFIG_UL    = 4'd10;
	localparam logic [ACTION_W-1:0] ACT_SET_RNTI     = 4'd11;

	// Classified event word, front end to back end
	typedef struct packed {
		logic [OP_W-1:0] op;
		logic            illegal;
		logic            set_cell;
		logic            set_dl_width;
		logic            set_ul;
		logic            set_rnti;
		logic            check_camp;
		logic            has_mobility;
		logic [15:0]     cell_id;
		logic [15:0]     dl_earfcn;
		logic [15:0]     ul_earfcn;
		logic [15:0]     rnti;
		logic [1:0]      transaction_id;
		logic [7:0]      dl_bandwidth;
		logic [7:0]      ul_bandwidth;
	} cmd_t;

	// Result word, back end to ports
	typedef struct packed {
		logic [STATE_W-1:0]  rrc_state;
		logic [ACTION_W-1:0] action;
		logic                start_random_access;
		logic                event_error;
		logic [1:0]          reply_transaction;
		logic [15:0]         current_rnti;
		logic [15:0]         serving_cell;
		logic [15:0]         dl_carrier;
		logic [15:0]         ul_carrier;
		logic [7:0]          dl_width;
		logic [7:0]          ul_width;
		logic [ID_W-1:0]     ue_identity;
	} res_t;

endpackage

/* sv/uerc_front.sv */
`timescale 1ns / 1ps
// Front end: classifies each event word into a command for the back end.
module uerc_front import uerc_pkg::*; (
	input  logic [OP_W-1:0] operation,
	input  logic [15:0]     cell_id,
	input  logic [15:0]     dl_earfcn,
	input  logic [15:0]     ul_earfcn,
	input  logic [15:0]     rnti,
	input  logic [1:0]      transaction_id,
	input  logic            has_mobility,
	input  logic            has_sib2,
	input  logic [7:0]      dl_bandwidth,
	input  logic [7:0]      ul_bandwidth,
	output cmd_t            cmd
);

	always_comb begin
		cmd                = '0;
		cmd.op             = operation;
		cmd.cell_id        = cell_id;
		cmd.dl_earfcn      = dl_earfcn;
		cmd.ul_earfcn      = ul_earfcn;
		cmd.rnti           = rnti;
		cmd.transaction_id = transaction_id;
		cmd.has_mobility   = has_mobility;
		cmd.dl_bandwidth   = dl_bandwidth;
		cmd.ul_bandwidth   = ul_bandwidth;
		unique case (operation) inside
			OP_CAMP: begin
				cmd.set_cell = 1'b1;
			end
			OP_MIB: begin
				cmd.set_dl_width = 1'b1;
				cmd.check_camp   = 1'b1;
			end
			OP_SYSINFO: begin
				// block type 2 carries the uplink setup; either way re-check camping
				cmd.set_ul     = has_sib2;
				cmd.check_camp = 1'b1;
			end
			OP_SET_RNTI: begin
				cmd.set_rnti = 1'b1;
			end
			OP_CONNECT, OP_DISCONNECT, OP_RA_OK, OP_RA_FAIL, OP_SETUP, OP_RECONFIG,
			OP_REESTAB, OP_REESTAB_REJ, OP_RELEASE, OP_REJECT: begin
				cmd.illegal = 1'b0;
			end
			default: begin
				cmd.illegal = 1'b1;
			end
		endcase
	end

endmodule

/* sv/uerc_cmd_fifo.sv */
`timescale 1ns / 1ps
// Short command queue between the front end and the back end.
module uerc_cmd_fifo import uerc_pkg::*; #(
	parameter int unsigned DEPTH = 2
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  cmd_t push_data,
	output logic pop_valid,
	input  logic pop_ready,
	output cmd_t pop_data
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	cmd_t          mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign push_ready = (count_q != CW'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* sv/uerc_back.sv */
`timescale 1ns / 1ps
// Back end: connection state, held values and the registered result word.
module uerc_back import uerc_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cmd_valid,
	output logic            cmd_ready,
	input  cmd_t            cmd,
	input  logic [ID_W-1:0] subscriber_identity,
	output logic            res_valid,
	input  logic            res_ready,
	output res_t            res
);

	logic [STATE_W-1:0] mode_q;
	logic               mib_q;
	logic               sib2_q;
	logic               pend_q;
	logic [15:0]        rnti_q;
	logic [15:0]        cell_q;
	logic [15:0]        dl_car_q;
	logic [15:0]        ul_car_q;
	logic [7:0]         dl_w_q;
	logic [7:0]         ul_w_q;
	logic [1:0]         last_tid_q;
	logic               res_valid_q;
	res_t               res_q;

	logic [STATE_W-1:0]  mode_n;
	logic                mib_n;
	logic                sib2_n;
	logic                pend_n;
	logic [15:0]         rnti_n;
	logic [15:0]         cell_n;
	logic [15:0]         dl_car_n;
	logic [15:0]         ul_car_n;
	logic [7:0]          dl_w_n;
	logic [7:0]          ul_w_n;
	logic [1:0]          last_tid_n;
	logic [ACTION_W-1:0] action_n;
	logic                err_n;
	logic                sra_n;
	logic [1:0]          reply_n;
	logic [ID_W-1:0]     ident_n;
	logic                enter_n;
	logic [STATE_W-1:0]  enter_st;
	logic                take;

	assign cmd_ready = !res_valid_q || res_ready;
	assign take      = cmd_valid && cmd_ready;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	always_comb begin
		mode_n     = mode_q;
		mib_n      = mib_q | cmd.set_dl_width;
		sib2_n     = sib2_q | cmd.set_ul;
		pend_n     = pend_q;
		rnti_n     = cmd.set_rnti ? cmd.rnti : rnti_q;
		cell_n     = cmd.set_cell ? cmd.cell_id : cell_q;
		dl_car_n   = cmd.set_cell ? cmd.dl_earfcn : dl_car_q;
		ul_car_n   = cmd.set_ul ? cmd.ul_earfcn : ul_car_q;
		dl_w_n     = cmd.set_dl_width ? cmd.dl_bandwidth : dl_w_q;
		ul_w_n     = cmd.set_ul ? cmd.ul_bandwidth : ul_w_q;
		last_tid_n = last_tid_q;
		action_n   = ACT_NONE;
		err_n      = cmd.illegal;
		sra_n      = 1'b0;
		reply_n    = 2'd0;
		ident_n    = '0;
		enter_n    = 1'b0;
		enter_st   = ST_SELECT;

		unique case (cmd.op) inside
			OP_CONNECT: begin
				if (mode_q == ST_SELECT || mode_q == ST_WAITSI) begin
					pend_n = 1'b1;
				end else if (mode_q == ST_CAMPED) begin
					pend_n = 1'b0;
					mode_n = ST_RA;
					sra_n  = 1'b1;
				end
			end
			OP_DISCONNECT: begin
				if (mode_q == ST_CONNECTING) begin
					action_n = ACT_ABORT;
					enter_n  = 1'b1;
					enter_st = ST_CAMPED;
				end else if (mode_q == ST_CONNECTED || mode_q == ST_REESTAB ||
				             mode_q == ST_HANDOVER) begin
					action_n = ACT_LEAVE_CONN;
					enter_n  = 1'b1;
					enter_st = ST_CAMPED;
				end else if (mode_q == ST_WAITSI || mode_q == ST_RA) begin
					err_n = 1'b1;
				end
			end
			OP_CAMP: begin
				action_n = ACT_SYNC_CELL;
				enter_n  = 1'b1;
				enter_st = ST_WAITSI;
			end
			OP_MIB, OP_SYSINFO: begin
				if (cmd.set_dl_width) begin
					action_n = ACT_SET_DL_BW;
				end else if (cmd.set_ul) begin
					action_n = ACT_CONFIG_UL;
				end
				if (cmd.check_camp && mode_q == ST_WAITSI && mib_n && sib2_n) begin
					enter_n  = 1'b1;
					enter_st = ST_CAMPED;
				end
			end
			OP_SET_RNTI: begin
				action_n = ACT_SET_RNTI;
			end
			OP_RA_OK: begin
				if (mode_q == ST_RA) begin
					action_n = ACT_CONN_REQ;
					ident_n  = subscriber_identity;
					enter_n  = 1'b1;
					enter_st = ST_CONNECTING;
				end else if (mode_q == ST_HANDOVER) begin
					action_n = ACT_RECONF_DONE;
					reply_n  = last_tid_q;
					enter_n  = 1'b1;
					enter_st = ST_CONNECTED;
				end else begin
					err_n = 1'b1;
				end
			end
			OP_RA_FAIL, OP_RELEASE: begin
				err_n = 1'b0;
			end
			OP_SETUP: begin
				if (mode_q == ST_CONNECTING) begin
					action_n = ACT_SETUP_DONE;
					reply_n  = cmd.transaction_id;
					enter_n  = 1'b1;
					enter_st = ST_CONNECTED;
				end else begin
					err_n = 1'b1;
				end
			end
			OP_RECONFIG: begin
				if (mode_q != ST_CONNECTED) begin
					err_n = 1'b1;
				end else if (cmd.has_mobility) begin
					// handover: adopt the target cell wholesale
					cell_n     = cmd.cell_id;
					dl_car_n   = cmd.dl_earfcn;
					ul_car_n   = cmd.ul_earfcn;
					dl_w_n     = cmd.dl_bandwidth;
					ul_w_n     = cmd.ul_bandwidth;
					rnti_n     = cmd.rnti;
					last_tid_n = cmd.transaction_id;
					action_n   = ACT_START_HO;
					enter_n    = 1'b1;
					enter_st   = ST_HANDOVER;
				end else begin
					action_n = ACT_RECONF_DONE;
					reply_n  = cmd.transaction_id;
				end
			end
			OP_REESTAB: begin
				err_n = (mode_q != ST_REESTAB);
			end
			OP_REESTAB_REJ: begin
				if (mode_q == ST_REESTAB) begin
					action_n = ACT_LEAVE_CONN;
					enter_n  = 1'b1;
					enter_st = ST_CAMPED;
				end else begin
					err_n = 1'b1;
				end
			end
			OP_REJECT: begin
				action_n = ACT_MAC_RESET;
				enter_n  = 1'b1;
				enter_st = ST_CAMPED;
			end
			default: begin
				err_n = 1'b1;
			end
		endcase

		// a pending connect turns entry to camped into random access at once
		if (enter_n) begin
			mode_n = enter_st;
			if (enter_st == ST_CAMPED && pend_n) begin
				pend_n = 1'b0;
				mode_n = ST_RA;
				sra_n  = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= ST_SELECT;
			mib_q       <= 1'b0;
			sib2_q      <= 1'b0;
			pend_q      <= 1'b0;
			rnti_q      <= '0;
			cell_q      <= '0;
			dl_car_q    <= '0;
			ul_car_q    <= '0;
			dl_w_q      <= '0;
			ul_w_q      <= '0;
			last_tid_q  <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (take) begin
				mode_q     <= mode_n;
				mib_q      <= mib_n;
				sib2_q     <= sib2_n;
				pend_q     <= pend_n;
				rnti_q     <= rnti_n;
				cell_q     <= cell_n;
				dl_car_q   <= dl_car_n;
				ul_car_q   <= ul_car_n;
				dl_w_q     <= dl_w_n;
				ul_w_q     <= ul_w_n;
				last_tid_q <= last_tid_n;
			end
			if (take) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			res_q.rrc_state           <= mode_n;
			res_q.action              <= action_n;
			res_q.start_random_access <= sra_n;
			res_q.event_error         <= err_n;
			res_q.reply_transaction   <= reply_n;
			res_q.current_rnti        <= rnti_n;
			res_q.serving_cell        <= cell_n;
			res_q.dl_carrier          <= dl_car_n;
			res_q.ul_carrier          <= ul_car_n;
			res_q.dl_width            <= dl_w_n;
			res_q.ul_width            <= ul_w_n;
			res_q.ue_identity         <= ident_n;
		end
	end

	a_err_keeps_state: assert property (@(posedge clk) disable iff (!arst_n)
		take && err_n |=> mode_q == $past(mode_q))
		else $error("rejected event changed the connection state");

	a_sra_in_ra: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.start_random_access |-> res_q.rrc_state == ST_RA)
		else $error("random access started outside random access state");

	a_conn_req_connecting: assert property (@(posedge clk) disable iff (!arst_n)
		take && action_n == ACT_CONN_REQ |=> mode_q == ST_CONNECTING)
		else $error("connection request without moving to connecting");

	a_no_pending_camped: assert property (@(posedge clk) disable iff (!arst_n)
		!(pend_q && mode_q == ST_CAMPED))
		else $error("connect left pending while camped");

endmodule

/* sv/ue_radio_connection_fsm_unit.sv */
`timescale 1ns / 1ps
// Top level of the radio connection state machine.
//
// Control state machine of a mobile terminal's radio connection: eight states from cell
// selection through connected and handover. Each input word is one event; each event gives
// exactly one result word with the new state, an action code, a start-random-access flag,
// an error flag, the reply transaction id, the held identity, cell, carriers and bandwidths,
// and the subscriber identity when a connection request goes out (zero otherwise). An event
// not allowed in the current state sets the error flag and changes nothing. The block takes
// one event per clock sustained while results are taken; a taken event is written into the
// command queue, and the back end's state update takes it from the head of the queue into
// the result register; that loop also sets the rate. The queue holds FIFO_DEPTH words, so
// the input takes up to FIFO_DEPTH more words while a result waits on the output before it
// stalls. Write the subscriber identity only while no event is in flight.
module ue_radio_connection_fsm_unit import uerc_pkg::*; #(
	parameter int unsigned FIFO_DEPTH = 2
) (
	input  logic                clk,
	input  logic                arst_n,
	// configuration
	input  logic                cfg_we,
	input  logic [ID_W-1:0]     cfg_wdata,
	// event channel
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [OP_W-1:0]     operation,
	input  logic [15:0]         cell_id,
	input  logic [15:0]         dl_earfcn,
	input  logic [15:0]         ul_earfcn,
	input  logic [15:0]         rnti,
	input  logic [1:0]          transaction_id,
	input  logic                has_mobility,
	input  logic                has_sib2,
	input  logic [7:0]          dl_bandwidth,
	input  logic [7:0]          ul_bandwidth,
	// result channel
	output logic                out_valid,
	input  logic                out_ready,
	output logic [STATE_W-1:0]  rrc_state,
	output logic [ACTION_W-1:0] action,
	output logic                start_random_access,
	output logic                event_error,
	output logic [1:0]          reply_transaction,
	output logic [15:0]         current_rnti,
	output logic [15:0]         serving_cell,
	output logic [15:0]         dl_carrier,
	output logic [15:0]         ul_carrier,
	output logic [7:0]          dl_width,
	output logic [7:0]          ul_width,
	output logic [ID_W-1:0]     ue_identity
);

	logic [ID_W-1:0] subscriber_identity_q;
	cmd_t            front_cmd;
	cmd_t            q_cmd;
	logic            q_valid;
	logic            q_ready;
	res_t            res;

	// Hold the permanent identity; it only matters for connection requests.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			subscriber_identity_q <= '0;
		end else if (cfg_we) begin
			subscriber_identity_q <= cfg_wdata;
		end
	end

	// Classify the event word; no state is consulted here.
	uerc_front u_front (
		.operation      (operation),
		.cell_id        (cell_id),
		.dl_earfcn      (dl_earfcn),
		.ul_earfcn      (ul_earfcn),
		.rnti           (rnti),
		.transaction_id (transaction_id),
		.has_mobility   (has_mobility),
		.has_sib2       (has_sib2),
		.dl_bandwidth   (dl_bandwidth),
		.ul_bandwidth   (ul_bandwidth),
		.cmd            (front_cmd)
	);

	// Decouple input acceptance from the state update and output stall.
	uerc_cmd_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (in_valid),
		.push_ready (in_ready),
		.push_data  (front_cmd),
		.pop_valid  (q_valid),
		.pop_ready  (q_ready),
		.pop_data   (q_cmd)
	);

	// Advance the connection state one command per cycle, while results are taken, into the result register.
	uerc_back u_back (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cmd_valid           (q_valid),
		.cmd_ready           (q_ready),
		.cmd                 (q_cmd),
		.subscriber_identity (subscriber_identity_q),
		.res_valid           (out_valid),
		.res_ready           (out_ready),
		.res                 (res)
	);

	assign rrc_state           = res.rrc_state;
	assign action              = res.action;
	assign start_random_access = res.start_random_access;
	assign event_error         = res.event_error;
	assign reply_transaction   = res.reply_transaction;
	assign current_rnti        = res.current_rnti;
	assign serving_cell        = res.serving_cell;
	assign dl_carrier          = res.dl_carrier;
	assign ul_carrier          = res.ul_carrier;
	assign dl_width            = res.dl_width;
	assign ul_width            = res.ul_width;
	assign ue_identity         = res.ue_identity;

endmodule

/* tb/ue_radio_connection_fsm_unit_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench of the radio connection state machine.
//
// A directed table walks the machine through every event, both idle and connected paths,
// handover and its completion, the error cases and an unused code; then random sessions
// (camp, master and system info, connect, access, setup, reconfigs, teardown) mixed with
// noise and broken sessions drive about 1800 more words. Every accepted event is run
// through a local model of the machine and the expected result word is queued; every
// accepted result word is compared field by field with the oldest queued one.
module ue_radio_connection_fsm_unit_tb;
	import uerc_pkg::*;

	localparam int unsigned      HALF_PERIOD  = 6;
	localparam int unsigned      CYCLE_LIMIT  = 400000;
	localparam int unsigned      DRAIN_CYCLES = 8;
	localparam int unsigned      HOLD_CYCLES  = 300;
	localparam int unsigned      RANDOM_WORDS = 1800;
	localparam int unsigned      SEGMENTS     = 4;
	localparam logic [ID_W-1:0]  IDENT_MAX    = 50'd999_999_999_999_999;

	// One event word as it goes on the input channel
	typedef struct packed {
		logic [OP_W-1:0] op;
		logic [15:0]     cell_id;
		logic [15:0]     dl_arfcn;
		logic [15:0]     ul_arfcn;
		logic [15:0]     rnti;
		logic [1:0]      tid;
		logic            mobility;
		logic            sib2;
		logic [7:0]      dl_bw;
		logic [7:0]      ul_bw;
	} event_t;

	// Event plus, for the obvious directed rows, the state, action and error typed in
	typedef struct packed {
		event_t              ev;
		logic                known;
		logic [STATE_W-1:0]  want_state;
		logic [ACTION_W-1:0] want_action;
		logic                want_error;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [ID_W-1:0] cfg_wdata;
	logic in_valid;
	logic in_ready;
	stim_row_t drv_row;
	logic out_valid;
	logic out_ready;
	logic [STATE_W-1:0] rrc_state;
	logic [ACTION_W-1:0] action;
	logic start_random_access;
	logic event_error;
	logic [1:0] reply_transaction;
	logic [15:0] current_rnti;
	logic [15:0] serving_cell;
	logic [15:0] dl_carrier;
	logic [15:0] ul_carrier;
	logic [7:0] dl_width;
	logic [7:0] ul_width;
	logic [ID_W-1:0] ue_identity;

	// Local copy of the machine state and the identity register
	logic [STATE_W-1:0] fsm_mode;
	logic               seen_mib;
	logic               seen_sib2;
	logic               connect_waiting;
	logic [15:0]        rnti_held;
	logic [15:0]        cell_held;
	logic [15:0]        dl_carrier_held;
	logic [15:0]        ul_carrier_held;
	logic [7:0]         dl_width_held;
	logic [7:0]         ul_width_held;
	logic [1:0]         handover_tid;
	logic [ID_W-1:0]    subscriber_id;
	logic               access_started;

	res_t      expected_results[$];
	stim_row_t directed_rows[$];
	int unsigned cycle_count = 0;
	int unsigned mismatches = 0;
	int unsigned words_sent = 0;
	int unsigned burst_left = 0;
	logic hold_req = 1'b0;

	always begin
		#HALF_PERIOD clk = 1'b1;
		#HALF_PERIOD clk = 1'b0;
	end

	ue_radio_connection_fsm_unit i_dut (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cfg_we              (cfg_we),
		.cfg_wdata           (cfg_wdata),
		.in_valid            (in_valid),
		.in_ready            (in_ready),
		.operation           (drv_row.ev.op),
		.cell_id             (drv_row.ev.cell_id),
		.dl_earfcn           (drv_row.ev.dl_arfcn),
		.ul_earfcn           (drv_row.ev.ul_arfcn),
		.rnti                (drv_row.ev.rnti),
		.transaction_id      (drv_row.ev.tid),
		.has_mobility        (drv_row.ev.mobility),
		.has_sib2            (drv_row.ev.sib2),
		.dl_bandwidth        (drv_row.ev.dl_bw),
		.ul_bandwidth        (drv_row.ev.ul_bw),
		.out_valid           (out_valid),
		.out_ready           (out_ready),
		.rrc_state           (rrc_state),
		.action              (action),
		.start_random_access (start_random_access),
		.event_error         (event_error),
		.reply_transaction   (reply_transaction),
		.current_rnti        (current_rnti),
		.serving_cell        (serving_cell),
		.dl_carrier          (dl_carrier),
		.ul_carrier          (ul_carrier),
		.dl_width            (dl_width),
		.ul_width            (ul_width),
		.ue_identity         (ue_identity)
	);

	// ---------------------------------------------------------------------------------
	// Local model of the machine
	// ---------------------------------------------------------------------------------

	// Every entry into camped with a connect waiting goes straight on to random access
	function automatic void move_to(logic [STATE_W-1:0] next);
		fsm_mode = next;
		if (fsm_mode == ST_CAMPED && connect_waiting) begin
			connect_waiting = 1'b0;
			fsm_mode = ST_RA;
			access_started = 1'b1;
		end
	endfunction

	function automatic void try_camp();
		if (fsm_mode == ST_WAITSI && seen_mib && seen_sib2)
			move_to(ST_CAMPED);
	endfunction

	// Apply one event to the local state and return the result word it gives
	function automatic res_t next_connection_result(event_t e);
		res_t r;
		r = '0;
		access_started = 1'b0;
		case (e.op)
		OP_CONNECT: begin
			if (fsm_mode == ST_SELECT || fsm_mode == ST_WAITSI) begin
				connect_waiting = 1'b1;
			end else if (fsm_mode == ST_CAMPED) begin
				connect_waiting = 1'b0;
				fsm_mode = ST_RA;
				access_started = 1'b1;
			end
		end
		OP_DISCONNECT: begin
			if (fsm_mode == ST_CONNECTING) begin
				r.action = ACT_ABORT;
				move_to(ST_CAMPED);
			end else if (fsm_mode >= ST_CONNECTED) begin
				r.action = ACT_LEAVE_CONN;
				move_to(ST_CAMPED);
			end else if (fsm_mode == ST_WAITSI || fsm_mode == ST_RA) begin
				r.event_error = 1'b1;
			end
		end
		OP_CAMP: begin
			cell_held = e.cell_id;
			dl_carrier_held = e.dl_arfcn;
			r.action = ACT_SYNC_CELL;
			move_to(ST_WAITSI);
		end
		OP_MIB: begin
			dl_width_held = e.dl_bw;
			seen_mib = 1'b1;
			r.action = ACT_SET_DL_BW;
			try_camp();
		end
		OP_SYSINFO: begin
			if (e.sib2) begin
				seen_sib2 = 1'b1;
				ul_width_held = e.ul_bw;
				ul_carrier_held = e.ul_arfcn;
				r.action = ACT_CONFIG_UL;
			end
			try_camp();
		end
		OP_SET_RNTI: begin
			rnti_held = e.rnti;
			r.action = ACT_SET_RNTI;
		end
		OP_RA_OK: begin
			if (fsm_mode == ST_RA) begin
				move_to(ST_CONNECTING);
				r.action = ACT_CONN_REQ;
				r.ue_identity = subscriber_id;
			end else if (fsm_mode == ST_HANDOVER) begin
				r.action = ACT_RECONF_DONE;
				r.reply_transaction = handover_tid;
				move_to(ST_CONNECTED);
			end else begin
				r.event_error = 1'b1;
			end
		end
		OP_SETUP: begin
			if (fsm_mode == ST_CONNECTING) begin
				move_to(ST_CONNECTED);
				r.action = ACT_SETUP_DONE;
				r.reply_transaction = e.tid;
			end else begin
				r.event_error = 1'b1;
			end
		end
		OP_RECONFIG: begin
			if (fsm_mode != ST_CONNECTED) begin
				r.event_error = 1'b1;
			end else if (e.mobility) begin
				// Handover: take over the target's cell, carriers, widths and identity
				move_to(ST_HANDOVER);
				cell_held = e.cell_id;
				dl_carrier_held = e.dl_arfcn;
				ul_carrier_held = e.ul_arfcn;
				dl_width_held = e.dl_bw;
				ul_width_held = e.ul_bw;
				rnti_held = e.rnti;
				handover_tid = e.tid;
				r.action = ACT_START_HO;
			end else begin
				r.action = ACT_RECONF_DONE;
				r.reply_transaction = e.tid;
			end
		end
		OP_REESTAB: begin
			if (fsm_mode != ST_REESTAB)
				r.event_error = 1'b1;
		end
		OP_REESTAB_REJ: begin
			if (fsm_mode == ST_REESTAB) begin
				r.action = ACT_LEAVE_CONN;
				move_to(ST_CAMPED);
			end else begin
				r.event_error = 1'b1;
			end
		end
		OP_RA_FAIL, OP_RELEASE: ;
		OP_REJECT: begin
			r.action = ACT_MAC_RESET;
			move_to(ST_CAMPED);
		end
		default: r.event_error = 1'b1;
		endcase
		r.rrc_state = fsm_mode;
		r.start_random_access = access_started;
		r.current_rnti = rnti_held;
		r.serving_cell = cell_held;
		r.dl_carrier = dl_carrier_held;
		r.ul_carrier = ul_carrier_held;
		r.dl_width = dl_width_held;
		r.ul_width = ul_width_held;
		return r;
	endfunction

	// ---------------------------------------------------------------------------------
	// Monitor: predict on every accepted event, check every accepted result
	// ---------------------------------------------------------------------------------

	task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		res_t want;
		if (arst_n) begin
			cycle_count++;
			if (cycle_count > CYCLE_LIMIT) begin
				$display("FAIL");
				$finish;
			end
			// Predict first so a same-edge result could still find its expectation
			if (in_valid && in_ready) begin
				want = next_connection_result(drv_row.ev);
				if (drv_row.known) begin
					want.rrc_state = drv_row.want_state;
					want.action = drv_row.want_action;
					want.event_error = drv_row.want_error;
				end
				expected_results.push_back(want);
			end
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					$error("result word with nothing expected");
					mismatches++;
				end else begin
					want = expected_results.pop_front();
					check_field("rrc_state", 64'(want.rrc_state), 64'(rrc_state));
					check_field("action", 64'(want.action), 64'(action));
					check_field("start_random_access", 64'(want.start_random_access),
						64'(start_random_access));
					check_field("event_error", 64'(want.event_error), 64'(event_error));
					check_field("reply_transaction", 64'(want.reply_transaction),
						64'(reply_transaction));
					check_field("current_rnti", 64'(want.current_rnti),
						64'(current_rnti));
					check_field("serving_cell", 64'(want.serving_cell),
						64'(serving_cell));
					check_field("dl_carrier", 64'(want.dl_carrier), 64'(dl_carrier));
					check_field("ul_carrier", 64'(want.ul_carrier), 64'(ul_carrier));
					check_field("dl_width", 64'(want.dl_width), 64'(dl_width));
					check_field("ul_width", 64'(want.ul_width), 64'(ul_width));
					check_field("ue_identity", 64'(want.ue_identity), 64'(ue_identity));
				end
			end
		end
	end

	// ---------------------------------------------------------------------------------
	// Result side: stall patterns, plus one long hold-off on request
	// ---------------------------------------------------------------------------------

	initial begin : result_sink
		int span;
		int style;
		logic [7:0] pat;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				// Hold off long enough for the queue inside the block to fill up
				hold_req = 1'b0;
				@(negedge clk) out_ready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
			end else begin
				style = $urandom_range(0, 3);
				span = $urandom_range(8, 64);
				pat = 8'($urandom);
				for (int k = 0; k < span; k++) begin
					@(negedge clk);
					case (style)
					0: out_ready <= 1'b1;
					1: out_ready <= 1'($urandom_range(0, 1));
					2: out_ready <= pat[k % 8];
					default: out_ready <= (k % 5) != 0;
					endcase
				end
			end
		end
	end

	// ---------------------------------------------------------------------------------
	// Event side
	// ---------------------------------------------------------------------------------

	function automatic event_t mk_event(logic [OP_W-1:0] op, logic [15:0] cid,
			logic [15:0] dlf, logic [15:0] ulf, logic [15:0] id, logic [1:0] tid,
			logic mob, logic sib2, logic [7:0] dlbw, logic [7:0] ulbw);
		event_t e;
		e = '{op, cid, dlf, ulf, id, tid, mob, sib2, dlbw, ulbw};
		return e;
	endfunction

	function automatic event_t rand_event(logic [OP_W-1:0] op);
		event_t e;
		e = mk_event(op, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
			2'($urandom), 1'($urandom), 1'($urandom), 8'($urandom), 8'($urandom));
		return e;
	endfunction

	// Directed row; known rows carry the state, action and error flag typed in
	function automatic void add_row(event_t e, logic known = 1'b0,
			logic [STATE_W-1:0] st = ST_SELECT, logic [ACTION_W-1:0] act = ACT_NONE,
			logic err = 1'b0);
		stim_row_t r;
		r = '{e, known, st, act, err};
		directed_rows.push_back(r);
	endfunction

	// Drop valid and leave the input idle; n gives the length of the gap
	task automatic idle_input(int unsigned n);
		if (n != 0) begin
			@(negedge clk) in_valid <= 1'b0;
			repeat (n - 1) @(negedge clk);
		end
	endtask

	// Offer one word and hold it until the block takes it
	task automatic send_word(stim_row_t r);
		@(negedge clk);
		drv_row <= r;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		words_sent++;
	endtask

	// Send in bursts of random length with random gaps between them
	task automatic offer(event_t e);
		stim_row_t r;
		r = '{e, 1'b0, ST_SELECT, ACT_NONE, 1'b0};
		if (burst_left == 0) begin
			if ($urandom_range(0, 3) != 0)
				idle_input($urandom_range(1, 10));
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		send_word(r);
	endtask

	// Wait until every expected word is back and the block has settled
	task automatic drain_pipeline();
		idle_input(1);
		while (expected_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_identity(logic [ID_W-1:0] value);
		drain_pipeline();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk) cfg_we <= 1'b0;
		subscriber_id = value;
	endtask

	// Well-formed session with random content, now and then broken
	task automatic run_session();
		event_t seq[$];
		event_t e;
		int unsigned n_reconf;
		int unsigned cut;
		logic early;
		early = 1'($urandom_range(0, 1));
		if (early) seq.push_back(rand_event(OP_CONNECT));
		seq.push_back(rand_event(OP_CAMP));
		if ($urandom_range(0, 3) == 0) begin
			e = rand_event(OP_SYSINFO);
			e.sib2 = 1'b0;
			seq.push_back(e);
		end
		e = rand_event(OP_SYSINFO);
		e.sib2 = 1'b1;
		if ($urandom_range(0, 1)) begin
			seq.push_back(rand_event(OP_MIB));
			seq.push_back(e);
		end else begin
			seq.push_back(e);
			seq.push_back(rand_event(OP_MIB));
		end
		if (!early) seq.push_back(rand_event(OP_CONNECT));
		if ($urandom_range(0, 1)) seq.push_back(rand_event(OP_SET_RNTI));
		seq.push_back(rand_event(OP_RA_OK));
		seq.push_back(rand_event(OP_SETUP));
		n_reconf = $urandom_range(0, 4);
		repeat (n_reconf) begin
			e = rand_event(OP_RECONFIG);
			seq.push_back(e);
			if (e.mobility) begin
				if ($urandom_range(0, 3) == 0) seq.push_back(rand_event(OP_RA_FAIL));
				seq.push_back(rand_event(OP_RA_OK));
			end
		end
		case ($urandom_range(0, 3))
		0: seq.push_back(rand_event(OP_DISCONNECT));
		1: seq.push_back(rand_event(OP_REJECT));
		2: seq.push_back(rand_event(OP_RELEASE));
		default: begin
			seq.push_back(rand_event(OP_RA_FAIL));
			seq.push_back(rand_event(OP_DISCONNECT));
		end
		endcase
		// Break some sessions: one word swapped for any code, or the tail cut off
		if ($urandom_range(0, 4) == 0)
			seq[$urandom_range(0, seq.size() - 1)] =
				rand_event(OP_W'($urandom_range(0, 15)));
		if ($urandom_range(0, 5) == 0) begin
			cut = $urandom_range(1, seq.size());
			while (seq.size() > cut) void'(seq.pop_back());
		end
		foreach (seq[i]) offer(seq[i]);
	endtask

	// ---------------------------------------------------------------------------------
	// Main sequence
	// ---------------------------------------------------------------------------------

	initial begin : stimulus
		logic [63:0] raw;
		logic [ID_W-1:0] ident;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		in_valid = 1'b0;
		drv_row = '0;

		fsm_mode = ST_SELECT;
		seen_mib = 1'b0;
		seen_sib2 = 1'b0;
		connect_waiting = 1'b0;
		rnti_held = '0;
		cell_held = '0;
		dl_carrier_held = '0;
		ul_carrier_held = '0;
		dl_width_held = '0;
		ul_width_held = '0;
		handover_tid = '0;
		subscriber_id = '0;
		access_started = 1'b0;

		repeat (2) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// Directed walk: idle side, access, setup, reconfig, handover, errors, teardown
		add_row(mk_event(OP_RA_OK, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, ST_SELECT, ACT_NONE, 1);
		add_row(mk_event(OP_DISCONNECT, 0, 0, 0, 0, 0, 0, 0, 0, 0),
			1, ST_SELECT, ACT_NONE, 0);
		add_row(mk_event(OP_CONNECT, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, ST_SELECT, ACT_NONE, 0);
		add_row(mk_event(OP_CAMP, 16'hFFFF, 16'h0000, 16'hFFFF, 0, 0, 0, 0, 0, 0),
			1, ST_WAITSI, ACT_SYNC_CELL, 0);
		add_row(mk_event(OP_DISCONNECT, 0, 0, 0, 0, 0, 0, 0, 0, 0),
			1, ST_WAITSI, ACT_NONE, 1);
		// system info without block type 2 only makes the camped check
		add_row(mk_event(OP_SYSINFO, 0, 0, 16'hFFFF, 0, 0, 0, 0, 8'hFF, 8'hFF),
			1, ST_WAITSI, ACT_NONE, 0);
		add_row(mk_event(OP_MIB, 0, 0, 0, 0, 0, 0, 0, 8'hFF, 0),
			1, ST_WAITSI, ACT_SET_DL_BW, 0);
		// camped with a connect pending: random access starts on the same event
		add_row(mk_event(OP_SYSINFO, 0, 0, 16'h0000, 0, 0, 0, 1, 0, 8'h00),
			1, ST_RA, ACT_CONFIG_UL, 0);
		add_row(mk_event(OP_DISCONNECT, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, ST_RA, ACT_NONE, 1);
		add_row(mk_event(OP_SET_RNTI, 0, 0, 0, 16'hFFFF, 0, 0, 0, 0, 0),
			1, ST_RA, ACT_SET_RNTI, 0);
		add_row(mk_event(OP_RA_OK, 0, 0, 0, 0, 0, 0, 0, 0, 0),
			1, ST_CONNECTING, ACT_CONN_REQ, 0);
		add_row(mk_event(OP_CONNECT, 0, 0, 0, 0, 0, 0, 0, 0, 0),
			1, ST_CONNECTING, ACT_NONE, 0);
		add_row(mk_event(OP_SETUP, 0, 0, 0, 0, 2'd3, 0, 0, 0, 0),
			1, ST_CONNECTED, ACT_SETUP_DONE, 0);
		add_row(mk_event(OP_RECONFIG, 16'h1234, 0, 0, 0, 2'd2, 0, 1, 0, 0));
		add_row(mk_event(OP_RECONFIG, 16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000, 2'd3, 1, 0,
			8'h00, 8'hFF), 1, ST_HANDOVER, ACT_START_HO, 0);
		add_row(mk_event(OP_SETUP, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, ST_HANDOVER, ACT_NONE, 1);
		add_row(mk_event(OP_RA_OK, 0, 0, 0, 0, 0, 0, 0, 0, 0),
			1, ST_CONNECTED, ACT_RECONF_DONE, 0);
		add_row(mk_event(OP_REESTAB, 0, 0, 0, 0, 0, 0, 0, 0, 0),
			1, ST_CONNECTED, ACT_NONE, 1);
		add_row(mk_event(OP_REESTAB_REJ, 0, 0, 0, 0, 0, 0, 0, 0, 0),
			1, ST_CONNECTED, ACT_NONE, 1);
		add_row(mk_event(OP_LAST + 1'b1, 0, 0, 0, 0, 0, 0, 0, 0, 0),
			1, ST_CONNECTED, ACT_NONE, 1);
		add_row(mk_event(OP_RA_FAIL, 0, 0, 0, 0, 0, 0, 0, 0, 0),
			1, ST_CONNECTED, ACT_NONE, 0);
		add_row(mk_event(OP_RELEASE, 0, 0, 0, 0, 0, 0, 0, 0, 0),
			1, ST_CONNECTED, ACT_NONE, 0);
		add_row(mk_event(OP_DISCONNECT, 0, 0, 0, 0, 0, 0, 0, 0, 0),
			1, ST_CAMPED, ACT_LEAVE_CONN, 0);
		add_row(mk_event(OP_CONNECT, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, ST_RA, ACT_NONE, 0);
		add_row(mk_event(OP_RA_OK, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		add_row(mk_event(OP_DISCONNECT, 0, 0, 0, 0, 0, 0, 0, 0, 0),
			1, ST_CAMPED, ACT_ABORT, 0);
		add_row(mk_event(OP_REJECT, 0, 0, 0, 0, 0, 0, 0, 0, 0),
			1, ST_CAMPED, ACT_MAC_RESET, 0);

		write_identity(IDENT_MAX);
		foreach (directed_rows[i]) begin
			if ($urandom_range(0, 2) == 0) idle_input($urandom_range(1, 4));
			send_word(directed_rows[i]);
		end

		// Random part, a new identity per segment; the long hold-off lands in segment 1
		for (int seg = 0; seg < SEGMENTS; seg++) begin
			raw = {$urandom, $urandom};
			case (seg)
			0: ident = '0;
			1: ident = IDENT_MAX;
			default: ident = ID_W'(raw % (64'(IDENT_MAX) + 64'd1));
			endcase
			write_identity(ident);
			if (seg == 1) begin
				hold_req = 1'b1;
				burst_left = 150;
			end
			while (words_sent < directed_rows.size() + (seg + 1) * RANDOM_WORDS / SEGMENTS)
			begin
				if ($urandom_range(0, 9) < 7) begin
					run_session();
				end else begin
					repeat ($urandom_range(1, 6))
						offer(rand_event(OP_W'($urandom_range(0, 15))));
				end
			end
		end

		drain_pipeline();
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
